// ===== rtl/bfp_pkg.sv =====
// bfp_pkg: shared types, codes and parameter defaults for the bit field packer.
// No dependencies.
package bfp_pkg;

    localparam int BUF_BYTES_DEF      = 4096;
    localparam int STACK_DEPTH_DEF    = 8;
    localparam int MAX_FIELD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_OPEN  = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERFLOW   = 2'd1,
        ST_NO_OPEN    = 2'd2,
        ST_STACK_FULL = 2'd3
    } t_status;

    // Mask of the n low bits of a byte, n in 1..8.
    function automatic logic [7:0] low_mask(input logic [3:0] n);
        return 8'hFF >> (4'd8 - n);
    endfunction

endpackage

// ===== rtl/bfp_ram.sv =====
// bfp_ram: generic single write port, single read port RAM, registered read.
// Read returns the old contents on a same-address write. No dependencies.
module bfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bit_field_packer_with_length_backfill.sv =====
// bit_field_packer_with_length_backfill: top level, sequencer and packing datapath.
// Depends on bfp_pkg and bfp_ram.
//
// Packs MSB-first bit fields into a byte store, with open/close items that reserve a
// length field and later back-fill it with the byte count of the enclosed data. One
// item is taken at a time. A write, open or close runs through one shared shift/merge
// unit that does one read-modify-write of the byte store per cycle, one for each byte
// the field touches (up to 5 for a 32-bit field). A rejected item or a zero-width field
// skips that unit, and a byte read does one registered read of the store instead. The
// input is free again the cycle after the result is loaded; no new item is taken
// before the last one is through, as the input stalls outside the idle state.
// The result sits in an output register, so the next item can be taken while it waits;
// a result still held there when the next one is ready stalls the sequencer and the
// input until it is taken. Store contents come out of reset undefined, with no
// clearing pass: bytes are treated as zero until the cursor has written them.
module bit_field_packer_with_length_backfill #(
    parameter int BUF_BYTES      = bfp_pkg::BUF_BYTES_DEF,
    parameter int STACK_DEPTH    = bfp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_FIELD_BITS = bfp_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_req_type,
    input  logic [31:0]                      i_field_value,
    input  logic [5:0]                       i_field_bits,
    input  logic [$clog2(BUF_BYTES)-1:0]     i_read_addr,
    input  logic                             i_restart,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_read_data,
    output logic [$clog2(BUF_BYTES+1)-1:0]   o_data_length,
    output logic [2:0]                       o_cursor_bit_pos,
    output logic [1:0]                       o_status
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int LW = $clog2(BUF_BYTES + 1);
    localparam int PW = LW + 4;
    localparam int NW = $clog2(MAX_FIELD_BITS + 1);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [PW-1:0] BIT_LIMIT = PW'(BUF_BYTES * 8);
    localparam logic [LW-1:0] BUF_END   = LW'(BUF_BYTES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_PACK  = 5'b00100,
        S_READ  = 5'b01000,
        S_POST  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    bfp_pkg::t_req    r_req, n_req;
    bfp_pkg::t_status r_status, n_status;
    logic [31:0]      r_val, n_val;
    logic [NW-1:0]    r_nbits, n_nbits;
    logic [AW-1:0]    r_addr, n_addr;
    logic [NW-1:0]    r_left, n_left;
    logic [LW-1:0]    r_cur, n_cur;
    logic [2:0]       r_bit, n_bit;
    logic [LW-1:0]    r_end, n_end;
    logic             r_fresh, n_fresh;
    logic [CW-1:0]    r_count, n_count;
    logic [7:0]       r_rdata, n_rdata;

    logic             r_o_valid, n_o_valid;
    logic [7:0]       r_o_rdata, n_o_rdata;
    logic [LW-1:0]    r_o_len, n_o_len;
    logic [2:0]       r_o_bit, n_o_bit;
    bfp_pkg::t_status r_o_status, n_o_status;

    logic [LW-1:0]    r_stk_fbyte [STACK_DEPTH];
    logic [2:0]       r_stk_fbit  [STACK_DEPTH];
    logic [LW-1:0]    r_stk_body  [STACK_DEPTH];
    logic [NW-1:0]    r_stk_width [STACK_DEPTH];

    logic             in_acc;
    logic             push_head, push_body;
    logic [CW-1:0]    cnt_dec;
    logic [SW-1:0]    push_idx, pop_idx;
    logic [PW-1:0]    end_pos;
    logic             fits;
    logic [LW-1:0]    close_len;

    logic [3:0]       room, take, sum_bit;
    logic [5:0]       left6, take6, shamt;
    logic [31:0]      shifted;
    logic [7:0]       chunk, old_byte, merged;
    logic             byte_done;
    logic [LW-1:0]    cur_inc;
    logic [LW-1:0]    rd_ext;

    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_q;

    bfp_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cur[AW-1:0]),
        .i_wdata (merged),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign cnt_dec  = r_count - CW'(1);
    assign push_idx = r_count[SW-1:0];
    assign pop_idx  = cnt_dec[SW-1:0];
    assign end_pos  = PW'({r_cur, r_bit}) + PW'(r_nbits);
    assign fits     = (end_pos <= BIT_LIMIT);
    assign close_len = r_cur - r_stk_body[pop_idx];

    // Shared shift/merge unit: one byte of the field per cycle.
    assign room     = 4'd8 - {1'b0, r_bit};
    assign left6    = 6'(r_left);
    assign take6    = (left6 < 6'(room)) ? left6 : 6'(room);
    assign take     = take6[3:0];
    assign shamt    = left6 - take6;
    assign shifted  = r_val >> shamt;
    assign chunk    = shifted[7:0] & bfp_pkg::low_mask(take);
    assign old_byte = (r_cur == r_end && r_fresh) ? 8'h00 : ram_q;
    assign merged   = old_byte | (chunk << 3'(room - take));
    assign sum_bit  = {1'b0, r_bit} + take;
    assign byte_done = sum_bit[3];
    assign cur_inc  = r_cur + LW'(1);
    assign ram_we   = (r_state == S_PACK) && (r_cur < BUF_END);

    assign rd_ext   = LW'(r_addr);
    assign ram_raddr = (r_state == S_CHECK && r_req == bfp_pkg::REQ_READ) ? r_addr
                                                                          : n_cur[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_status   = r_status;
        n_val      = r_val;
        n_nbits    = r_nbits;
        n_addr     = r_addr;
        n_left     = r_left;
        n_cur      = r_cur;
        n_bit      = r_bit;
        n_end      = r_end;
        n_fresh    = r_fresh;
        n_count    = r_count;
        n_rdata    = r_rdata;
        n_o_valid  = r_o_valid && i_stall;
        n_o_rdata  = r_o_rdata;
        n_o_len    = r_o_len;
        n_o_bit    = r_o_bit;
        n_o_status = r_o_status;
        push_head  = 1'b0;
        push_body  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req    = bfp_pkg::t_req'(i_req_type);
                    n_val    = i_field_value;
                    n_nbits  = (i_field_bits > 6'(MAX_FIELD_BITS)) ? NW'(MAX_FIELD_BITS)
                                                                    : NW'(i_field_bits);
                    n_addr   = i_read_addr;
                    n_status = bfp_pkg::ST_OK;
                    n_rdata  = 8'h00;
                    if (i_restart) begin
                        n_cur   = '0;
                        n_bit   = '0;
                        n_end   = '0;
                        n_count = '0;
                        n_fresh = 1'b1;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_POST;
                case (r_req)
                    bfp_pkg::REQ_WRITE: begin
                        if (!fits) begin
                            n_status = bfp_pkg::ST_OVERFLOW;
                        end else begin
                            n_left = r_nbits;
                            if (r_nbits != '0) n_state = S_PACK;
                        end
                    end
                    bfp_pkg::REQ_OPEN: begin
                        if (r_count >= CW'(STACK_DEPTH)) begin
                            n_status = bfp_pkg::ST_STACK_FULL;
                        end else if (!fits) begin
                            n_status = bfp_pkg::ST_OVERFLOW;
                        end else begin
                            push_head = 1'b1;
                            n_val     = '0;
                            n_left    = r_nbits;
                            if (r_nbits != '0) n_state = S_PACK;
                        end
                    end
                    bfp_pkg::REQ_CLOSE: begin
                        if (r_count == '0) begin
                            n_status = bfp_pkg::ST_NO_OPEN;
                        end else begin
                            n_count = cnt_dec;
                            n_val   = 32'(close_len);
                            n_left  = r_stk_width[pop_idx];
                            n_cur   = r_stk_fbyte[pop_idx];
                            n_bit   = r_stk_fbit[pop_idx];
                            if (r_stk_width[pop_idx] != '0) n_state = S_PACK;
                        end
                    end
                    default: begin
                        n_state = S_READ;
                    end
                endcase
            end
            S_PACK: begin
                n_left = r_left - NW'(take6);
                if (r_cur == r_end) n_fresh = 1'b0;
                if (byte_done) begin
                    n_bit = '0;
                    n_cur = cur_inc;
                    if (cur_inc > r_end) begin
                        n_end   = cur_inc;
                        n_fresh = 1'b1;
                    end
                end else begin
                    n_bit = sum_bit[2:0];
                end
                if (n_left == '0) n_state = S_POST;
            end
            S_READ: begin
                if (rd_ext <= r_end && rd_ext < BUF_END && !(rd_ext == r_end && r_fresh)) begin
                    n_rdata = ram_q;
                end
                n_state = S_POST;
            end
            S_POST: begin
                if (!r_o_valid || !i_stall) begin
                    if (r_status == bfp_pkg::ST_OK) begin
                        if (r_req == bfp_pkg::REQ_OPEN) begin
                            push_body = 1'b1;
                            n_count   = r_count + CW'(1);
                        end else if (r_req == bfp_pkg::REQ_CLOSE) begin
                            n_cur = r_end;
                            n_bit = '0;
                        end
                    end
                    n_o_valid  = 1'b1;
                    n_o_rdata  = r_rdata;
                    n_o_len    = r_end;
                    n_o_bit    = n_bit;
                    n_o_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_bit     <= '0;
            r_end     <= '0;
            r_fresh   <= 1'b1;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_bit     <= n_bit;
            r_end     <= n_end;
            r_fresh   <= n_fresh;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_status   <= n_status;
        r_val      <= n_val;
        r_nbits    <= n_nbits;
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_rdata    <= n_rdata;
        r_o_rdata  <= n_o_rdata;
        r_o_len    <= n_o_len;
        r_o_bit    <= n_o_bit;
        r_o_status <= n_o_status;
        if (push_head) begin
            r_stk_fbyte[push_idx] <= r_cur;
            r_stk_fbit[push_idx]  <= r_bit;
            r_stk_width[push_idx] <= r_nbits;
        end
        if (push_body) begin
            r_stk_body[push_idx] <= r_cur;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_read_data      = r_o_rdata;
    assign o_data_length    = r_o_len;
    assign o_cursor_bit_pos = r_o_bit;
    assign o_status         = r_o_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("mark count beyond stack depth");

    a_cursor_le_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_end)
        else $error("cursor past end of data");

    a_pack_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PACK) |-> (r_left != '0))
        else $error("pack step with no bits left");

    a_end_shrinks_on_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_end < $past(r_end))) |-> ($past(in_acc) && $past(i_restart)))
        else $error("end of data moved back without restart");

endmodule
